// ===== rtl/core/sync_length_crc_deframer_top_assert.svh =====
// assertion macros used by the deframer top level
`ifndef SYNC_LENGTH_CRC_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CRC_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SLCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// next-cycle implication, disabled while in reset
`define SLCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

// ===== rtl/core/slcd_pkg.sv =====
// shared types, codes and the crc update for the deframer
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [15:0] MAX_PAYLOAD   = 16'd4096;
   localparam logic [12:0] MAX_LEN_RESET = 13'd4096;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND   = 8'h55;

   // result kinds on the output
   localparam logic [1:0] RESULT_PAYLOAD = 2'd0;
   localparam logic [1:0] RESULT_GOOD    = 2'd1;
   localparam logic [1:0] RESULT_CRC_ERR = 2'd2;
   localparam logic [1:0] RESULT_LEN_ERR = 2'd3;

   // token kinds between front and back
   localparam logic [1:0] TOKEN_DATA    = 2'd0;
   localparam logic [1:0] TOKEN_END     = 2'd1;
   localparam logic [1:0] TOKEN_LEN_ERR = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] length;
      logic [15:0] crc;
   } token_type;

   // crc16 msb first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slcd_front.sv =====
// frame parser: sync hunt, length check, trailer capture
`timescale 1ns / 1ps
`default_nettype none

module slcd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 csr_write,
   input  wire logic [12:0]          csr_data,
   output logic                      token_push,
   output slcd_pkg::token_type       token
);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_SYNC1  = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;
   localparam logic [2:0] PH_CRC_HI = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [12:0] max_len_ff;
   logic [7:0]  length_low_ff, length_low_in;
   logic [15:0] payload_length_ff, payload_length_in;
   logic [12:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] len_word;
   logic [12:0] seen_next;
   logic        len_bad;

   assign len_word  = {rx_byte, length_low_ff};
   assign seen_next = bytes_seen_ff + 13'd1;
   assign len_bad   = (len_word == 16'd0) || (len_word > {3'b000, max_len_ff})
                   || (len_word > slcd_pkg::MAX_PAYLOAD);

   always_comb begin
      phase_in          = phase_ff;
      length_low_in     = length_low_ff;
      payload_length_in = payload_length_ff;
      bytes_seen_in     = bytes_seen_ff;
      crc_low_in        = crc_low_ff;
      token_push        = 1'b0;
      token             = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == slcd_pkg::SYNC_FIRST) begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_SYNC1: begin
               if (rx_byte == slcd_pkg::SYNC_SECOND) begin
                  phase_in = PH_LEN_LO;
               end else if (rx_byte != slcd_pkg::SYNC_FIRST) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN_LO: begin
               length_low_in = rx_byte;
               phase_in      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               payload_length_in = len_word;
               bytes_seen_in     = 13'd0;
               if (len_bad) begin
                  phase_in     = PH_HUNT;
                  token_push   = 1'b1;
                  token.kind   = slcd_pkg::TOKEN_LEN_ERR;
                  token.length = len_word;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               bytes_seen_in = seen_next;
               if ({3'b000, seen_next} >= payload_length_ff) begin
                  phase_in = PH_CRC_LO;
               end
               token_push = 1'b1;
               token.kind = slcd_pkg::TOKEN_DATA;
               token.data = rx_byte;
            end
            PH_CRC_LO: begin
               crc_low_in = rx_byte;
               phase_in   = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               phase_in     = PH_HUNT;
               token_push   = 1'b1;
               token.kind   = slcd_pkg::TOKEN_END;
               token.length = payload_length_ff;
               token.crc    = {rx_byte, crc_low_ff};
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         max_len_ff        <= slcd_pkg::MAX_LEN_RESET;
         length_low_ff     <= 8'd0;
         payload_length_ff <= 16'd0;
         bytes_seen_ff     <= 13'd0;
         crc_low_ff        <= 8'd0;
      end else begin
         phase_ff          <= phase_in;
         length_low_ff     <= length_low_in;
         payload_length_ff <= payload_length_in;
         bytes_seen_ff     <= bytes_seen_in;
         crc_low_ff        <= crc_low_in;
         if (csr_write) begin
            max_len_ff <= csr_data;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/slcd_queue.sv =====
// short token queue between parser and crc back end
`timescale 1ns / 1ps
`default_nettype none

module slcd_queue #(
   parameter int DEPTH = slcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire slcd_pkg::token_type      push_token,
   input  wire logic                     pop,
   output slcd_pkg::token_type           pop_token,
   output logic                          full,
   output logic                          empty,
   output logic [$clog2(DEPTH+1)-1:0]    count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   slcd_pkg::token_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign count     = count_ff;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_token = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/slcd_back.sv =====
// crc back end and result output register
`timescale 1ns / 1ps
`default_nettype none

module slcd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire slcd_pkg::token_type  q_token,
   output logic                      q_pop,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output logic [1:0]                rsp_result_kind,
   output logic [7:0]                rsp_payload_byte,
   output logic [15:0]               rsp_frame_length,
   output logic [15:0]               rsp_received_crc,
   output logic [15:0]               rsp_computed_crc
);

   logic        valid_ff;
   logic [15:0] crc_ff, crc_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic [15:0] ccrc_ff, ccrc_in;

   assign q_pop = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      crc_in    = crc_ff;
      kind_in   = slcd_pkg::RESULT_PAYLOAD;
      byte_in   = 8'd0;
      length_in = 16'd0;
      rcrc_in   = 16'd0;
      ccrc_in   = 16'd0;
      unique case (q_token.kind)
         slcd_pkg::TOKEN_DATA: begin
            crc_in  = slcd_pkg::crc16_byte(crc_ff, q_token.data);
            byte_in = q_token.data;
         end
         slcd_pkg::TOKEN_END: begin
            crc_in    = slcd_pkg::CRC_INIT;
            kind_in   = (q_token.crc == crc_ff) ? slcd_pkg::RESULT_GOOD
                                                : slcd_pkg::RESULT_CRC_ERR;
            length_in = q_token.length;
            rcrc_in   = q_token.crc;
            ccrc_in   = crc_ff;
         end
         default: begin
            kind_in   = slcd_pkg::RESULT_LEN_ERR;
            length_in = q_token.length;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         crc_ff   <= slcd_pkg::CRC_INIT;
      end else begin
         if (q_pop) begin
            valid_ff <= 1'b1;
            crc_ff   <= crc_in;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         length_ff <= length_in;
         rcrc_ff   <= rcrc_in;
         ccrc_ff   <= ccrc_in;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_received_crc = rcrc_ff;
   assign rsp_computed_crc = ccrc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sync_length_crc_deframer_top.sv =====
// top level of the sync, length and crc16 frame receiver
// byte-serial deframer: hunts for the sync pair aa 55, reads a little-endian
// 16-bit length, releases each payload byte as a payload word straight away
// (cut-through) while crc16 (init ffff, poly 1021, msb first) runs over them,
// then reads the crc trailer low byte first and gives one end word, good or
// crc error, carrying length, received crc and computed crc. a length of zero,
// above csr_max_len or above 4096 gives a length error word and hunting
// resumes. the receiver keeps or drops the released bytes on the end status.
// throughput is one byte per cycle while the result side pops: the crc update
// is one unrolled eight-bit step per cycle. an accepted byte reaches its result
// word through the token queue entry written by the parser and the output
// register. req_full rises only when QUEUE_DEPTH tokens wait behind a stalled
// result side. csr_max_len is always ready and must be written only while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "sync_length_crc_deframer_top_assert.svh"

module sync_length_crc_deframer_top #(
   parameter int QUEUE_DEPTH = slcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input, queue style
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   // result output, queue style
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_frame_length,
   output logic [15:0]      rsp_received_crc,
   output logic [15:0]      rsp_computed_crc,
   // max_len register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_max_len
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   logic                accept;
   logic                tok_push;
   slcd_pkg::token_type tok_in;
   slcd_pkg::token_type tok_out;
   logic                q_full;
   logic                q_empty;
   logic                q_pop;
   logic [CNT_W-1:0]    q_count;
   logic                word_good;
   logic                word_bad;

   // register port never stalls
   assign csr_ready = 1'b1;

   // a word is taken whenever the token queue has room
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: sync hunt, length check and trailer capture
   slcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_max_len),
      .token_push (tok_push),
      .token      (tok_in)
   );

   // decoupling queue so each side stalls on its own
   slcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (tok_push),
      .push_token (tok_in),
      .pop        (q_pop),
      .pop_token  (tok_out),
      .full       (q_full),
      .empty      (q_empty),
      .count      (q_count)
   );

   // back: crc over payload tokens, end status, output register
   slcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_token          (tok_out),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_received_crc (rsp_received_crc),
      .rsp_computed_crc (rsp_computed_crc)
   );

   // end words currently on show
   assign word_good = !rsp_empty && (rsp_result_kind == slcd_pkg::RESULT_GOOD);
   assign word_bad  = !rsp_empty && (rsp_result_kind == slcd_pkg::RESULT_CRC_ERR);

   // queue occupancy stays within its depth
   `SLCD_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH))

   // a good end word carries matching crcs, a crc error word differing ones
   `SLCD_ASSERT_NOW(a_good_crc, clock, reset, word_good, rsp_received_crc == rsp_computed_crc)
   `SLCD_ASSERT_NOW(a_bad_crc, clock, reset, word_bad, rsp_received_crc != rsp_computed_crc)

   // a token pushed into an empty queue with a free output moves on next cycle
   `SLCD_ASSERT_NEXT(a_pass_through, clock, reset, tok_push && q_empty && rsp_empty, q_pop)

endmodule

`default_nettype wire

// ===== sim/sync_length_crc_deframer_top_test.sv =====
// self-checking testbench for the sync, length and crc16 frame receiver
`timescale 1ns / 1ps

module sync_length_crc_deframer_top_test;

   // cycles allowed after the last expected word before the block counts as idle
   localparam int DRAIN_CYCLES = 6;

   // parser phases of the predictor, kept apart from the rtl encoding
   localparam logic [2:0] ST_HUNT      = 3'd0;
   localparam logic [2:0] ST_SYNC_SEEN = 3'd1;
   localparam logic [2:0] ST_LEN_LOW   = 3'd2;
   localparam logic [2:0] ST_LEN_HIGH  = 3'd3;
   localparam logic [2:0] ST_PAYLOAD   = 3'd4;
   localparam logic [2:0] ST_CRC_LOW   = 3'd5;
   localparam logic [2:0] ST_CRC_HIGH  = 3'd6;

   // one result word as it should leave the block
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] length;
      logic [15:0] rx_crc;
      logic [15:0] calc_crc;
   } deframer_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_frame_length;
   logic [15:0] rsp_received_crc;
   logic [15:0] rsp_computed_crc;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_max_len = 13'd0;

   // predictor state: its own copy of the parser and of max_len
   logic [2:0]   parse_state = ST_HUNT;
   logic [7:0]   len_low_q = 8'h00;
   logic [15:0]  frame_len_q = 16'h0000;
   logic [12:0]  byte_count = 13'd0;
   logic [15:0]  crc_acc = 16'hFFFF;
   logic [7:0]   trailer_low = 8'h00;
   logic [12:0]  max_len_shadow = slcd_pkg::MAX_LEN_RESET;

   deframer_word_type expected_words[$];
   logic [7:0]        frame_body[$];
   int                error_count = 0;
   int                bytes_sent = 0;
   bit                idle_on = 1'b1;

   sync_length_crc_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_received_crc (rsp_received_crc),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_len      (csr_max_len)
   );

   always #6 clock = ~clock;

   // crc16, msb first, worked one data bit at a time through the feedback tap
   function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r = {r[14:0], 1'b0} ^ (fb ? slcd_pkg::CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   // step the predicted parser by one accepted byte, queueing any word it yields
   function automatic void advance_parser(input logic [7:0] b);
      deframer_word_type w;
      logic [15:0]       len;
      logic [15:0]       trailer;
      w = '0;
      unique case (parse_state)
         ST_HUNT: begin
            if (b == slcd_pkg::SYNC_FIRST) parse_state = ST_SYNC_SEEN;
         end
         ST_SYNC_SEEN: begin
            // a second aa keeps us here, anything other than aa or 55 drops back to hunting
            if (b == slcd_pkg::SYNC_SECOND) parse_state = ST_LEN_LOW;
            else if (b != slcd_pkg::SYNC_FIRST) parse_state = ST_HUNT;
         end
         ST_LEN_LOW: begin
            len_low_q = b;
            parse_state = ST_LEN_HIGH;
         end
         ST_LEN_HIGH: begin
            len = {b, len_low_q};
            frame_len_q = len;
            if (len == 16'd0 || len > max_len_shadow || len > slcd_pkg::MAX_PAYLOAD) begin
               w.kind = slcd_pkg::RESULT_LEN_ERR;
               w.length = len;
               expected_words.push_back(w);
               parse_state = ST_HUNT;
            end else begin
               byte_count = 13'd0;
               crc_acc = slcd_pkg::CRC_INIT;
               parse_state = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            // cut-through: every payload byte comes straight out
            crc_acc = crc_update(crc_acc, b);
            byte_count = byte_count + 13'd1;
            if ({3'b000, byte_count} >= frame_len_q) parse_state = ST_CRC_LOW;
            w.kind = slcd_pkg::RESULT_PAYLOAD;
            w.data = b;
            expected_words.push_back(w);
         end
         ST_CRC_LOW: begin
            trailer_low = b;
            parse_state = ST_CRC_HIGH;
         end
         ST_CRC_HIGH: begin
            trailer = {b, trailer_low};
            w.kind = (trailer == crc_acc) ? slcd_pkg::RESULT_GOOD : slcd_pkg::RESULT_CRC_ERR;
            w.length = frame_len_q;
            w.rx_crc = trailer;
            w.calc_crc = crc_acc;
            expected_words.push_back(w);
            parse_state = ST_HUNT;
         end
         default: begin
            parse_state = ST_HUNT;
         end
      endcase
   endfunction

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
         error_count++;
      end
   endtask

   // result side: pop stalls at random unless idling is off
   always @(posedge clock) begin
      rsp_pop <= !idle_on || ($urandom_range(99) >= 29);
   end

   // every word taken from the block is matched against the oldest expectation
   always @(posedge clock) begin
      deframer_word_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got kind %0d byte %h len %h",
                     $time, rsp_result_kind, rsp_payload_byte, rsp_frame_length);
            error_count++;
         end else begin
            w = expected_words.pop_front();
            check_field("result_kind", {14'd0, w.kind}, {14'd0, rsp_result_kind});
            check_field("payload_byte", {8'd0, w.data}, {8'd0, rsp_payload_byte});
            check_field("frame_length", w.length, rsp_frame_length);
            check_field("received_crc", w.rx_crc, rsp_received_crc);
            check_field("computed_crc", w.calc_crc, rsp_computed_crc);
         end
      end
   end

   // offer one byte, with random idle cycles in front, and predict once it is taken
   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 29) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      advance_parser(b);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [15:0] len);
      send_byte(slcd_pkg::SYNC_FIRST);
      send_byte(slcd_pkg::SYNC_SECOND);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   // header, the bytes in frame_body, then the trailer, optionally spoilt
   task automatic send_frame(input bit spoil);
      logic [15:0] crc;
      crc = slcd_pkg::CRC_INIT;
      send_header(16'(frame_body.size()));
      foreach (frame_body[i]) begin
         send_byte(frame_body[i]);
         crc = crc_update(crc, frame_body[i]);
      end
      if (spoil) crc = crc ^ 16'($urandom_range(1, 65535));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   task automatic fill_body(input int n);
      frame_body.delete();
      repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
   endtask

   // stop pushing, let every expected word out, then let the block settle
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // max_len is only written with the block idle
   task automatic write_max_len(input logic [12:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_max_len <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_len_shadow = v;
   endtask

   // sync hunting, repeated and broken sync, zero and oversized length, good and bad crc
   task automatic test_sync_and_framing();
      send_byte(8'h00);
      // aa then a full frame: the first-sync state holds through the repeat
      frame_body = '{8'h00};
      send_byte(slcd_pkg::SYNC_FIRST);
      send_frame(1'b0);
      send_byte(slcd_pkg::SYNC_FIRST);
      send_byte(8'h13);
      send_header(16'h0000);
      send_header(16'h1001);
      // payload carrying sync bytes, trailer spoilt
      frame_body = '{8'hFF, 8'h55, 8'hAA};
      send_frame(1'b1);
   endtask

   // max_len at its extremes and the payload ceiling
   task automatic test_length_limits();
      write_max_len(13'd1);
      frame_body = '{8'h5A};
      send_frame(1'b0);
      send_header(16'd2);
      write_max_len(13'd0);
      send_header(16'd1);
      write_max_len(13'h1FFF);
      send_header(16'hFFFF);
      send_header(16'd4097);
      // a longer frame under the widest setting
      fill_body(64);
      send_frame(1'b0);
      write_max_len(13'd4095);
      send_header(16'd4096);
      write_max_len(slcd_pkg::MAX_LEN_RESET);
      fill_body(3);
      send_frame(1'b0);
   endtask

   // mostly well-formed frames with random content, some noise and broken frames
   task automatic test_random_traffic();
      int          phase_end;
      int          pick;
      int          cap;
      int          lim;
      logic [12:0] setting;
      for (int p = 0; p < 6; p++) begin
         case ($urandom_range(3))
            0: setting = slcd_pkg::MAX_LEN_RESET;
            1: setting = 13'($urandom_range(1, 40));
            2: setting = 13'h1FFF;
            default: setting = 13'($urandom_range(0, 8191));
         endcase
         write_max_len(setting);
         // one phase runs flat out on both sides
         idle_on = (p != 3);
         phase_end = bytes_sent + 252;
         while (bytes_sent < phase_end) begin
            pick = $urandom_range(99);
            cap = (max_len_shadow > slcd_pkg::MAX_PAYLOAD) ? int'(slcd_pkg::MAX_PAYLOAD)
                                                            : int'(max_len_shadow);
            lim = (cap == 0) ? 1 : cap;
            if (pick < 6) lim = (lim > 200) ? 200 : lim;
            else lim = (lim > 16) ? 16 : lim;
            if (pick < 72) begin
               fill_body($urandom_range(1, lim));
               send_frame(pick >= 60);
            end else if (pick < 82) begin
               case ($urandom_range(2))
                  0: send_header(16'h0000);
                  1: send_header(16'(cap + 1));
                  default: send_header(16'($urandom_range(0, 65535)));
               endcase
            end else if (pick < 90) begin
               send_byte(slcd_pkg::SYNC_FIRST);
               send_byte(8'($urandom_range(0, 255)));
            end else begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_sync_and_framing();
      test_length_limits();
      test_random_traffic();
      wait_drained();
      if (error_count == 0) begin
         $display("sync_length_crc_deframer_top_test: clean");
      end else begin
         $display("sync_length_crc_deframer_top_test: errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("sync_length_crc_deframer_top_test: errors");
      $finish;
   end

endmodule

// ===== sync_length_crc_deframer_top.f =====
+incdir+rtl/core
rtl/core/slcd_pkg.sv
rtl/core/slcd_front.sv
rtl/core/slcd_queue.sv
rtl/core/slcd_back.sv
rtl/core/sync_length_crc_deframer_top.sv
sim/sync_length_crc_deframer_top_test.sv
